>>> src/fsp_pkg.sv
// Shared types, character codes and helpers for the format string printer.
package fsp_pkg;

  // Argument width and the derived digit counts
  localparam int unsigned ARG_BITS = 32;
  // decimal digits needed for ARG_BITS bits: ceil(ARG_BITS * log10(2))
  localparam int unsigned NDIG     = (ARG_BITS * 30103 + 99999) / 100000;
  localparam int unsigned DIG_W    = 4 * NDIG;
  localparam int unsigned IDX_W    = $clog2(NDIG);
  localparam int unsigned CNT_W    = $clog2(ARG_BITS + 1);

  // ASCII codes used by the decoder and digit mapping
  localparam logic [7:0] CH_PCT   = 8'h25;  // '%'
  localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_UA    = 8'h41;  // 'A'
  localparam logic [7:0] CH_LA    = 8'h61;  // 'a'
  localparam logic [7:0] CH_C     = 8'h63;  // 'c'
  localparam logic [7:0] CH_D     = 8'h64;  // 'd'
  localparam logic [7:0] CH_U     = 8'h75;  // 'u'
  localparam logic [7:0] CH_LX    = 8'h78;  // 'x'
  localparam logic [7:0] CH_UX    = 8'h58;  // 'X'

  // Input beat: one format character and its argument word
  typedef struct packed {
    logic [7:0]          fmt_char;
    logic [ARG_BITS-1:0] arg_value;
  } in_item_t;

  // Output beat: one character, last marks the end of an item's text
  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
  } out_item_t;

  // Request to the conversion unit
  typedef struct packed {
    logic                start;
    logic                hex;
    logic [ARG_BITS-1:0] value;
  } conv_req_t;

  // Map a digit value (0..15) to its ASCII character
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    base = upper ? CH_UA : CH_LA;
    if (d < 4'd10) begin
      digit_char = CH_ZERO + {4'b0000, d};
    end else begin
      digit_char = base + {4'b0000, d} - 8'd10;
    end
  endfunction

endpackage

>>> src/format_string_number_printer_top.sv
// Top level: format character decoder, digit emitter and output register.
//
// Usage: feed one format character per input beat on in_*, each with its
// argument word. Each beat yields zero or more characters on out_*; the final
// character of a beat carries last. A '%' yields nothing and arms the next
// character as a conversion letter (c, d, u, x, X, %); any other letter gives
// '%' followed by the letter.
// One item at a time: in_ready_o is high only while the sequencer is idle.
// A plain character or a single-character conversion passes through the
// decode and last-character states and the output register to out_valid_o.
// Decimal conversion runs through the shared shift/add-3 unit at one
// argument bit per cycle, then scans the digit positions from the top
// (10 positions, leading zeros skipped). Hex loads the unit directly and
// then scans the same 10 positions.
// A single output register sits between the sequencer and out_*; the next
// input beat is taken as soon as the last character is in that register.
// When the receiver stalls, the output register holds and the sequencer
// waits. Reset clears the pending '%' and returns to idle; no output beat.
module format_string_number_printer_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  fsp_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output fsp_pkg::out_item_t out_data_o
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_DECODE = 6'b000010,
    ST_PRE    = 6'b000100,
    ST_LAST   = 6'b001000,
    ST_CONV   = 6'b010000,
    ST_DIG    = 6'b100000
  } state_e;

  state_e                     state_q, state_d;
  fsp_pkg::in_item_t          item_q;
  logic                       pend_q, pend_d;
  logic [7:0]                 c0_q, c0_d;
  logic [7:0]                 c1_q, c1_d;
  logic                       pre_conv_q, pre_conv_d;
  logic                       upper_q, upper_d;
  logic [fsp_pkg::IDX_W-1:0]  idx_q, idx_d;
  logic                       started_q, started_d;
  logic                       out_valid_q;
  fsp_pkg::out_item_t         out_q;

  fsp_pkg::conv_req_t         conv_req;
  logic [fsp_pkg::DIG_W-1:0]  conv_digits;
  logic                       conv_done;

  logic                       out_free;
  logic                       emit;
  fsp_pkg::out_item_t         emit_data;
  logic [fsp_pkg::ARG_BITS-1:0] arg_mag;
  logic [3:0]                 cur_dig;
  logic                       in_fire;

  fsp_conv u_conv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (conv_req),
    .digits_o (conv_digits),
    .done_o   (conv_done)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign arg_mag    = ~item_q.arg_value + 1'b1;
  assign cur_dig    = conv_digits[{idx_q, 2'b00} +: 4];

  // sequencer
  always_comb begin
    state_d        = state_q;
    pend_d         = pend_q;
    c0_d           = c0_q;
    c1_d           = c1_q;
    pre_conv_d     = pre_conv_q;
    upper_d        = upper_q;
    idx_d          = idx_q;
    started_d      = started_q;
    emit           = 1'b0;
    emit_data      = '{out_char: c1_q, last: 1'b1};
    conv_req       = '{start: 1'b0, hex: 1'b0, value: item_q.arg_value};

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_DECODE;
        end
      end

      ST_DECODE: begin
        if (!pend_q) begin
          if (item_q.fmt_char == fsp_pkg::CH_PCT) begin
            pend_d  = 1'b1;
            state_d = ST_IDLE;
          end else begin
            c1_d    = item_q.fmt_char;
            state_d = ST_LAST;
          end
        end else begin
          pend_d = 1'b0;
          case (item_q.fmt_char) inside
            fsp_pkg::CH_C: begin
              c1_d    = item_q.arg_value[7:0];
              state_d = ST_LAST;
            end
            fsp_pkg::CH_PCT: begin
              c1_d    = fsp_pkg::CH_PCT;
              state_d = ST_LAST;
            end
            fsp_pkg::CH_D: begin
              conv_req.start = 1'b1;
              upper_d        = 1'b0;
              if (item_q.arg_value[fsp_pkg::ARG_BITS-1]) begin
                // negative: print '-' while the magnitude converts
                conv_req.value = arg_mag;
                c0_d           = fsp_pkg::CH_MINUS;
                pre_conv_d     = 1'b1;
                state_d        = ST_PRE;
              end else begin
                state_d = ST_CONV;
              end
            end
            fsp_pkg::CH_U: begin
              conv_req.start = 1'b1;
              upper_d        = 1'b0;
              state_d        = ST_CONV;
            end
            fsp_pkg::CH_LX, fsp_pkg::CH_UX: begin
              conv_req.start = 1'b1;
              conv_req.hex   = 1'b1;
              upper_d        = (item_q.fmt_char == fsp_pkg::CH_UX);
              state_d        = ST_CONV;
            end
            default: begin
              // unknown letter: echo the percent, then the letter
              c0_d       = fsp_pkg::CH_PCT;
              c1_d       = item_q.fmt_char;
              pre_conv_d = 1'b0;
              state_d    = ST_PRE;
            end
          endcase
        end
      end

      ST_PRE: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_data = '{out_char: c0_q, last: 1'b0};
          state_d   = pre_conv_q ? ST_CONV : ST_LAST;
        end
      end

      ST_LAST: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_data = '{out_char: c1_q, last: 1'b1};
          state_d   = ST_IDLE;
        end
      end

      ST_CONV: begin
        if (conv_done) begin
          idx_d     = fsp_pkg::IDX_W'(fsp_pkg::NDIG - 1);
          started_d = 1'b0;
          state_d   = ST_DIG;
        end
      end

      ST_DIG: begin
        // scan from the top digit, skipping leading zeros; digit 0 always prints
        if (started_q || cur_dig != 4'd0 || idx_q == '0) begin
          if (out_free) begin
            emit      = 1'b1;
            emit_data = '{out_char: fsp_pkg::digit_char(cur_dig, upper_q),
                          last: (idx_q == '0)};
            started_d = 1'b1;
            if (idx_q == '0) begin
              state_d = ST_IDLE;
            end else begin
              idx_d = idx_q - 1'b1;
            end
          end
        end else begin
          idx_d = idx_q - 1'b1;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_data_i;
    end
    if (emit) begin
      out_q <= emit_data;
    end
    c0_q       <= c0_d;
    c1_q       <= c1_d;
    pre_conv_q <= pre_conv_d;
    upper_q    <= upper_d;
    idx_q      <= idx_d;
    started_q  <= started_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  a_accept_decodes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == ST_DECODE)
    else $error("input beat not followed by decode");

  a_last_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && emit_data.last) |=> state_q == ST_IDLE)
    else $error("sequencer busy after the last character");

  a_digits_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIG |-> conv_done)
    else $error("digit scan while conversion still running");

  a_no_emit_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> out_free)
    else $error("character written over a held output beat");

endmodule

>>> src/fsp_conv.sv
// Iterative binary to BCD converter (shift and add-3), with a direct hex load.
module fsp_conv (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  fsp_pkg::conv_req_t         req_i,
  output logic [fsp_pkg::DIG_W-1:0]  digits_o,
  output logic                       done_o
);

  logic [fsp_pkg::DIG_W-1:0]    bcd_q;
  logic [fsp_pkg::ARG_BITS-1:0] bin_q;
  logic [fsp_pkg::CNT_W-1:0]    cnt_q;
  logic                         busy_q;
  logic [fsp_pkg::DIG_W-1:0]    adj;

  // add 3 to every BCD digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < int'(fsp_pkg::NDIG); i++) begin
      if (bcd_q[i*4 +: 4] >= 4'd5) begin
        adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
      end else begin
        adj[i*4 +: 4] = bcd_q[i*4 +: 4];
      end
    end
  end

  // control: busy while bits remain to be shifted in
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= !req_i.hex;
      cnt_q  <= fsp_pkg::CNT_W'(fsp_pkg::ARG_BITS);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == fsp_pkg::CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // datapath: one bit per cycle; hex nibbles are the digits as they are
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      bin_q <= req_i.value;
      if (req_i.hex) begin
        bcd_q <= fsp_pkg::DIG_W'(req_i.value);
      end else begin
        bcd_q <= '0;
      end
    end else if (busy_q) begin
      bcd_q <= {adj[fsp_pkg::DIG_W-2:0], bin_q[fsp_pkg::ARG_BITS-1]};
      bin_q <= {bin_q[fsp_pkg::ARG_BITS-2:0], 1'b0};
    end
  end

  assign digits_o = bcd_q;
  assign done_o   = !busy_q;

endmodule
